// ----- src/bfe_pkg.sv -----
// ----------------------------------------------------------------------------
// bfe_pkg
// shared types and constants of the bloom filter engine: word layouts,
// register indexes, command codes and hash constants
// ----------------------------------------------------------------------------
package bfe_pkg;

  // field widths
  localparam int KEY_W      = 64;
  localparam int COUNT_W    = 32;
  localparam int HASH_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int FB_W       = 13;
  localparam int HC_W       = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // parameter defaults
  localparam int DEF_MAX_BYTES  = 4096;
  localparam int DEF_MAX_PROBES = 30;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BYTES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT   = 4'd1;

  // register reset values
  localparam logic [FB_W-1:0] FB_RESET = 13'd4096;
  localparam logic [HC_W-1:0] HC_RESET = 5'd6;

  // command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // murmur2 style hash constants
  localparam logic [HASH_W-1:0] MIX_MUL   = 32'h5bd1_e995;
  localparam logic [HASH_W-1:0] HASH_SEED = 32'hbc9f_1d34;
  localparam logic [HASH_W-1:0] KEY_LEN   = 32'd8;
  localparam logic [HASH_W-1:0] HASH_INIT = HASH_SEED ^ KEY_LEN;
  localparam int MIX_SHIFT   = 24;
  localparam int FIN_SHIFT_A = 13;
  localparam int FIN_SHIFT_B = 15;
  localparam int STRIDE_ROT  = 15;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
  } bfe_in_t;

  typedef struct packed {
    logic               may_contain;
    logic [COUNT_W-1:0] keys_added;
  } bfe_out_t;

endpackage

// ----- src/bfe_ram.sv -----
// ----------------------------------------------------------------------------
// bfe_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bfe_rem.sv -----
// ----------------------------------------------------------------------------
// bfe_rem
// iterative remainder unit, restoring method, one dividend bit per cycle
// ----------------------------------------------------------------------------
module bfe_rem #(
  parameter int NB_W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bfe_pkg::HASH_W-1:0] dividend_i,
  input  logic [NB_W-1:0]           divisor_i,
  output logic                      done_o,
  output logic [NB_W-1:0]           rem_o
);

  localparam int CW = $clog2(bfe_pkg::HASH_W);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [bfe_pkg::HASH_W-1:0] dvd_q, dvd_d;
  logic [NB_W-1:0]            rem_q, rem_d;
  logic [NB_W:0]              shifted;

  // partial remainder stays below the divisor, so the shifted value is below twice it
  assign shifted = {rem_q, dvd_q[bfe_pkg::HASH_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[bfe_pkg::HASH_W-2:0], 1'b0};
      if (shifted >= {1'b0, divisor_i}) begin
        rem_d = NB_W'(shifted - {1'b0, divisor_i});
      end else begin
        rem_d = shifted[NB_W-1:0];
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(bfe_pkg::HASH_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/bloom_filter_engine.sv -----
// ----------------------------------------------------------------------------
// bloom_filter_engine
// bloom filter over 64-bit keys with murmur2 hashing and double-hashed probes
// ----------------------------------------------------------------------------
// After reset the block first clears its bit store, one byte per cycle,
// over all MAX_BYTES bytes (4096 by default); in_ready_o stays low until
// that sweep is over, while register writes are taken at any time. Each
// word then takes one key at a time: eight hashing steps on a single shared
// 32-bit multiplier, three passes of a bit-serial remainder unit (hash,
// stride and 2^32, each modulo the filter size in bits), then a read state
// and a check-and-update state per probe of the bit store and a done state
// to hand over the result; a query stops at its first clear bit. With a
// filter size of zero a word skips hashing and probing and goes straight
// to the done state. The result word sits in an output register; the next
// key can be accepted while it waits.
// ----------------------------------------------------------------------------
module bloom_filter_engine #(
  parameter int MAX_BYTES  = bfe_pkg::DEF_MAX_BYTES,
  parameter int MAX_PROBES = bfe_pkg::DEF_MAX_PROBES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // key words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bfe_pkg::bfe_in_t               in_data_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bfe_pkg::bfe_out_t              out_data_o,
  // register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfe_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW      = $clog2(MAX_BYTES);
  localparam int BYTES_W = $clog2(MAX_BYTES + 1);
  localparam int NB_W    = BYTES_W + 3;
  localparam int PR_W    = $clog2(MAX_PROBES + 1);
  localparam int HW      = bfe_pkg::HASH_W;

  // sequencer states
  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_HASH    = 4'd2;
  localparam logic [3:0] ST_REM_H   = 4'd3;
  localparam logic [3:0] ST_REM_S   = 4'd4;
  localparam logic [3:0] ST_REM_W   = 4'd5;
  localparam logic [3:0] ST_PRB_RD  = 4'd6;
  localparam logic [3:0] ST_PRB_CHK = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  // hash steps on the shared multiplier
  localparam logic [2:0] HS_K1A = 3'd0;
  localparam logic [2:0] HS_K1B = 3'd1;
  localparam logic [2:0] HS_H1  = 3'd2;
  localparam logic [2:0] HS_K2A = 3'd3;
  localparam logic [2:0] HS_K2B = 3'd4;
  localparam logic [2:0] HS_H2  = 3'd5;
  localparam logic [2:0] HS_FM  = 3'd6;
  localparam logic [2:0] HS_FX  = 3'd7;

  // configuration registers
  logic [bfe_pkg::FB_W-1:0] fb_q;
  logic [bfe_pkg::HC_W-1:0] hc_q;

  // control state
  logic [3:0]               state_q, state_d;
  logic [AW-1:0]            clr_q, clr_d;
  logic [2:0]               hstep_q, hstep_d;
  logic [PR_W-1:0]          cnt_q, cnt_d;
  logic                     rem_go_q, rem_go_d;
  logic                     out_valid_q, out_valid_d;
  logic [bfe_pkg::COUNT_W-1:0] count_q, count_d;

  // working registers
  logic                     cmd_q, cmd_d;
  logic [bfe_pkg::KEY_W-1:0] key_q, key_d;
  logic [NB_W-1:0]          n_q, n_d;
  logic [HW-1:0]            h_q, h_d;
  logic [HW-1:0]            k_q, k_d;
  logic [HW-1:0]            stride_q, stride_d;
  logic [NB_W-1:0]          r_q, r_d;
  logic [NB_W-1:0]          s_q, s_d;
  logic [NB_W-1:0]          w_q, w_d;
  logic                     carry_q, carry_d;
  logic [2:0]               bit_q, bit_d;
  logic [AW-1:0]            addr_q, addr_d;
  logic                     result_q, result_d;
  bfe_pkg::bfe_out_t        out_data_q, out_data_d;

  // shared multiplier, low half only
  logic [HW-1:0]            mul_op;
  logic [HW-1:0]            mul_lo;
  logic [HW-1:0]            h_fin;

  // remainder unit
  logic [HW-1:0]            rem_dvd;
  logic                     rem_done;
  logic [NB_W-1:0]          rem_val;
  logic [NB_W:0]            w_inc;

  // probe arithmetic
  logic [HW:0]              h_sum;
  logic [NB_W:0]            rs_sum;

  // bit store
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [bfe_pkg::BYTE_W-1:0] ram_wdata;
  logic                     ram_re;
  logic [bfe_pkg::BYTE_W-1:0] ram_rdata;
  logic [bfe_pkg::BYTE_W-1:0] bit_mask;
  logic                     bit_set;

  // effective sizes from the registers
  logic [BYTES_W-1:0]       bytes_eff;
  logic [bfe_pkg::HC_W-1:0] hc_min;
  logic [PR_W-1:0]          probes_eff;

  logic in_acc;
  logic out_acc;
  logic out_free;

  // ---------------------------------------------------------------------------
  // register port, always ready
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q <= bfe_pkg::FB_RESET;
      hc_q <= bfe_pkg::HC_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bfe_pkg::REG_FILTER_BYTES) begin
        fb_q <= cfg_data_i[bfe_pkg::FB_W-1:0];
      end else if (cfg_index_i == bfe_pkg::REG_HASH_COUNT) begin
        hc_q <= cfg_data_i[bfe_pkg::HC_W-1:0];
      end
    end
  end

  // oversized store clamps to the physical size, probe count clamps to 1..MAX_PROBES
  assign bytes_eff = (32'(fb_q) > 32'(MAX_BYTES)) ? BYTES_W'(MAX_BYTES) : BYTES_W'(fb_q);
  assign hc_min    = (hc_q == '0) ? bfe_pkg::HC_W'(1) : hc_q;
  assign probes_eff = (32'(hc_min) > 32'(MAX_PROBES)) ? PR_W'(MAX_PROBES) : PR_W'(hc_min);

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;
  // output register can take a new word when empty or being drained
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // shared multiplier: every multiply of the hash is by the same constant
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (hstep_q)
      HS_K1A:  mul_op = key_q[HW-1:0];
      HS_K2A:  mul_op = key_q[2*HW-1:HW];
      HS_K1B,
      HS_K2B:  mul_op = k_q ^ (k_q >> bfe_pkg::MIX_SHIFT);
      HS_H1,
      HS_H2:   mul_op = h_q;
      HS_FM:   mul_op = h_q ^ (h_q >> bfe_pkg::FIN_SHIFT_A);
      default: mul_op = '0;
    endcase
  end

  assign mul_lo = mul_op * bfe_pkg::MIX_MUL;
  assign h_fin  = h_q ^ (h_q >> bfe_pkg::FIN_SHIFT_B);

  // ---------------------------------------------------------------------------
  // remainder unit, shared by the hash, the stride and 2^32
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (state_q)
      ST_REM_H: rem_dvd = h_q;
      ST_REM_S: rem_dvd = stride_q;
      default:  rem_dvd = '1;
    endcase
  end

  bfe_rem #(
    .NB_W (NB_W)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_go_q),
    .dividend_i (rem_dvd),
    .divisor_i  (n_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // 2^32 mod n from (2^32 - 1) mod n plus one
  assign w_inc = {1'b0, rem_val} + (NB_W + 1)'(1);

  // ---------------------------------------------------------------------------
  // probe stepping: the position follows the 32-bit hash modulo n without a
  // division, adding the stride residue and taking 2^32 mod n back out on wrap
  // ---------------------------------------------------------------------------
  assign h_sum  = {1'b0, h_q} + {1'b0, stride_q};
  assign rs_sum = {1'b0, r_q} + {1'b0, s_q};

  assign bit_mask = bfe_pkg::BYTE_W'(1) << bit_q;
  assign bit_set  = |(ram_rdata & bit_mask);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    hstep_d     = hstep_q;
    cnt_d       = cnt_q;
    rem_go_d    = 1'b0;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    n_d         = n_q;
    h_d         = h_q;
    k_d         = k_q;
    stride_d    = stride_q;
    r_d         = r_q;
    s_d         = s_q;
    w_d         = w_q;
    carry_d     = carry_q;
    bit_d       = bit_q;
    addr_d      = addr_q;
    result_d    = result_q;
    out_data_d  = out_data_q;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MAX_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          cmd_d    = in_data_i.cmd;
          key_d    = in_data_i.key;
          n_d      = {bytes_eff, 3'b000};
          cnt_d    = probes_eff;
          h_d      = bfe_pkg::HASH_INIT;
          hstep_d  = HS_K1A;
          result_d = 1'b1;
          // no filter: nothing to hash or probe
          state_d  = (bytes_eff == '0) ? ST_DONE : ST_HASH;
        end
      end

      ST_HASH: begin
        hstep_d = hstep_q + 3'd1;
        unique case (hstep_q)
          HS_K1A, HS_K1B, HS_K2A, HS_K2B: k_d = mul_lo;
          HS_H1, HS_H2:                   h_d = mul_lo ^ k_q;
          HS_FM:                          h_d = mul_lo;
          default: begin
            h_d      = h_fin;
            stride_d = {h_fin[HW-1-bfe_pkg::STRIDE_ROT:0],
                        h_fin[HW-1:HW-bfe_pkg::STRIDE_ROT]};
            rem_go_d = 1'b1;
            state_d  = ST_REM_H;
          end
        endcase
      end

      ST_REM_H: begin
        if (rem_done) begin
          r_d      = rem_val;
          rem_go_d = 1'b1;
          state_d  = ST_REM_S;
        end
      end

      ST_REM_S: begin
        if (rem_done) begin
          s_d      = rem_val;
          rem_go_d = 1'b1;
          state_d  = ST_REM_W;
        end
      end

      ST_REM_W: begin
        if (rem_done) begin
          w_d     = (w_inc == {1'b0, n_q}) ? '0 : w_inc[NB_W-1:0];
          state_d = ST_PRB_RD;
        end
      end

      ST_PRB_RD: begin
        // byte read issued from the current position, position moves on
        bit_d   = r_q[2:0];
        addr_d  = r_q[AW+2:3];
        h_d     = h_sum[HW-1:0];
        carry_d = h_sum[HW];
        r_d     = (rs_sum >= {1'b0, n_q}) ? NB_W'(rs_sum - {1'b0, n_q}) : rs_sum[NB_W-1:0];
        state_d = ST_PRB_CHK;
      end

      ST_PRB_CHK: begin
        if (carry_q) begin
          r_d = (r_q >= w_q) ? (r_q - w_q) : (r_q - w_q + n_q);
        end
        cnt_d = cnt_q - PR_W'(1);
        if ((cmd_q == bfe_pkg::CMD_QUERY) && !bit_set) begin
          result_d = 1'b0;
          state_d  = ST_DONE;
        end else if (cnt_q == PR_W'(1)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_PRB_RD;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          if ((cmd_q == bfe_pkg::CMD_ADD) && (n_q != '0) && (count_q != '1)) begin
            count_d = count_q + bfe_pkg::COUNT_W'(1);
          end
          out_data_d.may_contain = result_q;
          out_data_d.keys_added  = count_d;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hstep_q     <= HS_K1A;
      cnt_q       <= '0;
      rem_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hstep_q     <= hstep_d;
      cnt_q       <= cnt_d;
      rem_go_q    <= rem_go_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    n_q        <= n_d;
    h_q        <= h_d;
    k_q        <= k_d;
    stride_q   <= stride_d;
    r_q        <= r_d;
    s_q        <= s_d;
    w_q        <= w_d;
    carry_q    <= carry_d;
    bit_q      <= bit_d;
    addr_q     <= addr_d;
    result_q   <= result_d;
    out_data_q <= out_data_d;
  end

  // ---------------------------------------------------------------------------
  // bit store: cleared by the sweep, read-modify-write on adds
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    if (state_q == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if ((state_q == ST_PRB_CHK) && (cmd_q == bfe_pkg::CMD_ADD)) begin
      ram_we    = 1'b1;
      ram_waddr = addr_q;
      ram_wdata = ram_rdata | bit_mask;
    end
  end

  assign ram_re = (state_q == ST_PRB_RD);

  bfe_ram #(
    .WIDTH (bfe_pkg::BYTE_W),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (r_q[AW+2:3]),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the running position and both residues stay below the filter size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRB_RD) |-> ((r_q < n_q) && (s_q < n_q) && (w_q < n_q)))
    else $error("probe residue out of range");

  // key count only ever steps up by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> (count_q == $past(count_q) + bfe_pkg::COUNT_W'(1)))
    else $error("key count jumped");

  // the remainder unit only reports while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> ((state_q == ST_REM_H) || (state_q == ST_REM_S) || (state_q == ST_REM_W)))
    else $error("remainder result outside a remainder state");

  // queries never write the bit store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q != ST_CLEAR)) |-> (cmd_q == bfe_pkg::CMD_ADD))
    else $error("store written during a query");

  // a result word only appears after the sequencer finished an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result word without a finished item");

endmodule

// ----- tb/bfe_check.sv -----
// ----------------------------------------------------------------------------
// bfe_check
// watches the register, key and result channels of the bloom filter engine,
// keeps its own copy of the bit store and the key count, works out the answer
// to every key word and compares each result word with the oldest one due
// ----------------------------------------------------------------------------
module bfe_check #(
  parameter int MAX_BYTES  = bfe_pkg::DEF_MAX_BYTES,
  parameter int MAX_PROBES = bfe_pkg::DEF_MAX_PROBES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           key_valid_i,
  input  logic                           key_ready_i,
  input  bfe_pkg::bfe_in_t               key_word_i,
  input  logic                           res_valid_i,
  input  logic                           res_ready_i,
  input  bfe_pkg::bfe_out_t              res_word_i,
  input  logic                           reg_valid_i,
  input  logic                           reg_ready_i,
  input  logic [bfe_pkg::CFG_IDX_W-1:0]  reg_index_i,
  input  logic [bfe_pkg::CFG_DATA_W-1:0] reg_data_i,
  output int                             errors_o,
  output int                             pending_o
);

  import bfe_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic [BYTE_W-1:0]  shadow_bits [MAX_BYTES];
  logic [COUNT_W-1:0] added_cnt;
  logic [FB_W-1:0]    fb_reg;
  logic [HC_W-1:0]    hc_reg;
  bfe_out_t           answer_q [$];
  int                 errs = 0;
  int                 seen = 0;

  function automatic logic [HASH_W-1:0] mix_word(input logic [HASH_W-1:0] h,
                                                 input logic [HASH_W-1:0] k);
    logic [HASH_W-1:0] m;
    m = k * MIX_MUL;
    m = m ^ (m >> MIX_SHIFT);
    m = m * MIX_MUL;
    return (h * MIX_MUL) ^ m;
  endfunction

  function automatic logic [HASH_W-1:0] key_hash(input logic [KEY_W-1:0] key);
    logic [HASH_W-1:0] h;
    h = mix_word(HASH_INIT, key[31:0]);
    h = mix_word(h, key[63:32]);
    h = h ^ (h >> FIN_SHIFT_A);
    h = h * MIX_MUL;
    h = h ^ (h >> FIN_SHIFT_B);
    return h;
  endfunction

  // runs the probes of one key against the shadow store, queues the answer
  task automatic probe_filter(input bfe_in_t w);
    int unsigned       bytes;
    int unsigned       probes;
    int unsigned       nbits;
    int unsigned       pos;
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] stride;
    bfe_out_t          ans;
    bytes  = (fb_reg > MAX_BYTES) ? MAX_BYTES : fb_reg;
    probes = (hc_reg == 0) ? 1 : ((hc_reg > MAX_PROBES) ? MAX_PROBES : hc_reg);
    ans.may_contain = 1'b1;
    if (bytes != 0) begin
      nbits  = bytes * 8;
      h      = key_hash(w.key);
      stride = {h[HASH_W-STRIDE_ROT-1:0], h[HASH_W-1:HASH_W-STRIDE_ROT]};
      for (int i = 0; i < probes; i++) begin
        pos = h % nbits;
        if (w.cmd == CMD_QUERY) begin
          if (!shadow_bits[(pos >> 3) % MAX_BYTES][pos & 7]) ans.may_contain = 1'b0;
        end else begin
          shadow_bits[(pos >> 3) % MAX_BYTES][pos & 7] = 1'b1;
        end
        h = h + stride;
      end
      if (w.cmd == CMD_ADD && added_cnt != '1) added_cnt = added_cnt + 1'b1;
    end
    ans.keys_added = added_cnt;
    answer_q.push_back(ans);
  endtask

  task automatic note_error(input string what, input logic [COUNT_W-1:0] want_v,
                            input logic [COUNT_W-1:0] got_v);
    errs++;
    if (errs <= REPORT_LIMIT)
      $display("result word %0d: %s expected %0h got %0h", seen, what, want_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_words
    bfe_out_t want;
    if (!rst_ni) begin
      for (int b = 0; b < MAX_BYTES; b++) shadow_bits[b] = '0;
      added_cnt = '0;
      fb_reg    = FB_RESET;
      hc_reg    = HC_RESET;
      answer_q.delete();
      pending_o <= 0;
      errors_o  <= errs;
    end else begin
      if (reg_valid_i && reg_ready_i) begin
        if (reg_index_i == REG_FILTER_BYTES) fb_reg = reg_data_i[FB_W-1:0];
        else if (reg_index_i == REG_HASH_COUNT) hc_reg = reg_data_i[HC_W-1:0];
      end
      // a result word never belongs to the key taken at the same edge
      if (res_valid_i && res_ready_i) begin
        if (answer_q.size() == 0) begin
          note_error("word with nothing due, keys_added", '0, res_word_i.keys_added);
        end else begin
          want = answer_q.pop_front();
          if (res_word_i.may_contain !== want.may_contain)
            note_error("may_contain", want.may_contain, res_word_i.may_contain);
          if (res_word_i.keys_added !== want.keys_added)
            note_error("keys_added", want.keys_added, res_word_i.keys_added);
        end
        seen++;
      end
      if (key_valid_i && key_ready_i) probe_filter(key_word_i);
      pending_o <= answer_q.size();
      errors_o  <= errs;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bloom filter engine: a short directed run over
// the register extremes and corner behaviour, then random phases of add and
// query words under random idling on both channels; bfe_check predicts and
// compares every result word, this module only drives and gives the verdict
// ----------------------------------------------------------------------------
module tb_top;

  import bfe_pkg::*;

  localparam int MAX_GAP      = 16;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int DRAIN_CYCLES = 500;
  localparam int HOLD_CYCLES  = 3000;
  localparam int HOLD_AT_A    = 300;
  localparam int HOLD_AT_B    = 800;
  localparam int QUIET_SPAN   = 64;
  localparam int POOL_DEPTH   = 64;
  localparam int PHASES       = 10;
  localparam int RAND_ITEMS   = 1130;
  localparam int SPARE_LO     = REG_HASH_COUNT + 1;
  localparam int SPARE_HI     = (1 << CFG_IDX_W) - 1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  key_valid = 1'b0;
  logic                  key_ready;
  bfe_in_t               key_word  = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  bfe_out_t              res_word;
  logic                  reg_valid = 1'b0;
  logic                  reg_ready;
  logic [CFG_IDX_W-1:0]  reg_index = '0;
  logic [CFG_DATA_W-1:0] reg_data  = '0;
  int                    errors;
  int                    pending;
  int unsigned           cycle_cnt = 0;
  bit                    send_quiet = 1'b0;
  logic [KEY_W-1:0]      key_pool [$];

  // 10 time unit period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bloom_filter_engine uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (key_valid),
    .in_ready_o  (key_ready),
    .in_data_i   (key_word),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_data_o  (res_word),
    .cfg_valid_i (reg_valid),
    .cfg_ready_o (reg_ready),
    .cfg_index_i (reg_index),
    .cfg_data_i  (reg_data)
  );

  bfe_check u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .key_valid_i (key_valid),
    .key_ready_i (key_ready),
    .key_word_i  (key_word),
    .res_valid_i (res_valid),
    .res_ready_i (res_ready),
    .res_word_i  (res_word),
    .reg_valid_i (reg_valid),
    .reg_ready_i (reg_ready),
    .reg_index_i (reg_index),
    .reg_data_i  (reg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // watchdog: the slowest legal run is well under a third of this
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("[bloom_filter_engine] ERROR");
    $finish;
  end

  // idle cycles before a word, none at all during a quiet stretch
  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // mostly dense random keys, sometimes a single bit set or a single bit clear
  function automatic logic [KEY_W-1:0] fresh_key();
    case ($urandom_range(0, 7))
      0:       return 64'd1 << $urandom_range(0, KEY_W - 1);
      1:       return ~(64'd1 << $urandom_range(0, KEY_W - 1));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // offers one key word; valid stays up on return so that a back-to-back
  // word never drops it, the caller or the next gap lowers it
  task automatic push_key(input logic cmd, input logic [KEY_W-1:0] key);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      key_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_valid <= 1'b1;
    key_word  <= '{cmd: cmd, key: key};
    @(posedge clk);
    while (!key_ready) @(posedge clk);
  endtask

  // adds a key and keeps it for later queries that should hit
  task automatic add_key(input logic [KEY_W-1:0] key);
    push_key(CMD_ADD, key);
    key_pool.push_back(key);
    if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    reg_valid <= 1'b1;
    reg_index <= idx;
    reg_data  <= data;
    @(posedge clk);
    while (!reg_ready) @(posedge clk);
  endtask

  // stops offering keys and waits for every outstanding answer
  task automatic wait_idle();
    key_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // new register setting on an idle block; a write to an unused index rides
  // along each time and must change nothing
  task automatic configure(input logic [CFG_DATA_W-1:0] fb_data,
                           input logic [CFG_DATA_W-1:0] hc_data);
    logic [CFG_IDX_W-1:0] spare;
    spare = $urandom_range(SPARE_LO, SPARE_HI);
    wait_idle();
    write_reg(REG_FILTER_BYTES, fb_data);
    write_reg(spare, $urandom());
    write_reg(REG_HASH_COUNT, hc_data);
    reg_valid  <= 1'b0;
    send_quiet  = ($urandom_range(0, 3) == 0);
  endtask

  // adds and queries of keys already added, with some queries
  // of unknown keys, repeated adds and the odd full pause of the sender
  task automatic run_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 149) == 0) wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 40 || key_pool.size() == 0)
        add_key(fresh_key());
      else if (pick < 75)
        push_key(CMD_QUERY, key_pool[$urandom_range(0, key_pool.size() - 1)]);
      else if (pick < 92)
        push_key(CMD_QUERY, fresh_key());
      else
        add_key(key_pool[$urandom_range(0, key_pool.size() - 1)]);
    end
  endtask

  // result side: random stall before each word, quiet stretches now and then,
  // and two long hold-offs so the engine backs up into the key channel
  initial begin : drain_results
    int stall;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    @(posedge clk);
    forever begin
      if (taken % QUIET_SPAN == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = (taken == HOLD_AT_A || taken == HOLD_AT_B) ? HOLD_CYCLES : draw_wait(quiet);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: full store, six probes, nothing added yet
    push_key(CMD_QUERY, '0);
    add_key('0);
    push_key(CMD_QUERY, '0);
    add_key('1);
    push_key(CMD_QUERY, '1);
    push_key(CMD_QUERY, 64'h8000_0000_0000_0000);
    push_key(CMD_QUERY, 64'h0000_0000_0000_0001);
    add_key(64'h5555_5555_5555_5555);
    push_key(CMD_QUERY, 64'haaaa_aaaa_aaaa_aaaa);

    // no filter: add leaves the count alone, any query answers maybe
    configure(32'd0, 32'd6);
    add_key(64'h0123_4567_89ab_cdef);
    push_key(CMD_QUERY, 64'hfedc_ba98_7654_3210);

    // size beyond the store is clipped, a probe count of zero acts as one
    configure(32'hffff_ffff, 32'hffff_ffe0);
    add_key(64'hdead_beef_0000_0001);
    push_key(CMD_QUERY, 64'hdead_beef_0000_0001);
    push_key(CMD_QUERY, 64'hdead_beef_0000_0002);

    // smallest store, probe count above range clipped to the maximum
    configure(32'd1, 32'd31);
    add_key(64'h0000_0000_ffff_ffff);
    push_key(CMD_QUERY, 64'h0000_0000_ffff_ffff);
    push_key(CMD_QUERY, 64'hffff_ffff_0000_0000);

    // back to the full store: bits set under the small size stay put
    configure(32'd4096, 32'd30);
    push_key(CMD_QUERY, 64'h0000_0000_ffff_ffff);
    add_key(64'h0f0f_0f0f_f0f0_f0f0);
    push_key(CMD_QUERY, 64'h0f0f_0f0f_f0f0_f0f0);

    // random phases, register extremes first, then random settings with
    // junk in the unused upper data bits
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       configure(32'd4096, 32'd6);
        1:       configure(32'd1, 32'd1);
        2:       configure(32'd0, $urandom());
        3:       configure(32'h0000_1fff, 32'd30);
        4:       configure(32'd64, 32'd0);
        5:       configure(32'd13, 32'd31);
        default: configure($urandom_range(1, DEF_MAX_BYTES) | ($urandom() & 32'hffff_e000),
                           $urandom());
      endcase
      run_random(RAND_ITEMS / PHASES);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[bloom_filter_engine] OK");
    end else begin
      $display("[bloom_filter_engine] ERROR");
    end
    $finish;
  end

endmodule
